// ===== design/tbci_pkg.sv =====
`default_nettype none

package tbci_pkg;

  localparam int unsigned NUM_CH   = 4;
  localparam int unsigned CNT_BITS = 32;
  localparam int unsigned BIN_BITS = 16;
  localparam int unsigned CFG_BITS = 48;

  // configuration register indexes
  localparam logic REG_BIN_WIDTH = 1'b0;
  localparam logic REG_NUM_BINS  = 1'b1;

  localparam logic [CFG_BITS-1:0] BIN_WIDTH_RST = 48'd1000000;
  localparam logic [BIN_BITS-1:0] NUM_BINS_RST  = 16'd50;

endpackage

`default_nettype wire

// ===== design/time_binned_charge_integrator.sv =====
// Time-binned charge integrator for four-channel digitizer samples.
// Input channel (in_valid_i / in_ready_o): one sample word per handshake; a word
// with event_start_i high opens an event and carries its timestamp. Words before
// the first event, and all words after the last bin has closed, are taken and
// dropped.
// Output channel (out_valid_o / out_ready_i): one word per closed bin with its
// index, event count and the four mean charges, truncated toward zero.
// Configuration: cfg_we_i writes bin_width (index 0) or num_bins (index 1);
// write only while the block is idle.
// Throughput: a word that closes no bin is taken back to back, one per cycle,
// while no division runs. A word that closes a bin starts one shared radix-2
// divider, which runs the four channels in turn (load, step, store); in_ready_o
// stays low until the output step loads the result into the output register and
// raises out_valid_o, which waits while a previous result is not taken.
// A held result sits in the output register; the next bin's division can run
// behind it and waits only to hand over its result.
// Reset: all state is cleared, bin_width returns to 1000000 and num_bins to 50.
`default_nettype none

module time_binned_charge_integrator #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned TIME_BITS   = 48,
  parameter int unsigned SUM_BITS    = 48
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic                                 cfg_idx_i,
  input  wire logic [TIME_BITS-1:0]                 cfg_wdata_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic                                 event_start_i,
  input  wire logic [TIME_BITS-1:0]                 event_time_i,
  input  wire logic signed [SAMPLE_BITS-1:0]        amp_a_i,
  input  wire logic signed [SAMPLE_BITS-1:0]        amp_b_i,
  input  wire logic signed [SAMPLE_BITS-1:0]        amp_c_i,
  input  wire logic signed [SAMPLE_BITS-1:0]        amp_d_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [tbci_pkg::BIN_BITS-1:0]             bin_index_o,
  output logic [tbci_pkg::CNT_BITS-1:0]             event_count_o,
  output logic signed [SUM_BITS-1:0]                mean_a_o,
  output logic signed [SUM_BITS-1:0]                mean_b_o,
  output logic signed [SUM_BITS-1:0]                mean_c_o,
  output logic signed [SUM_BITS-1:0]                mean_d_o
);

  localparam int unsigned NCH   = tbci_pkg::NUM_CH;
  localparam int unsigned CW    = tbci_pkg::CNT_BITS;
  localparam int unsigned BW    = tbci_pkg::BIN_BITS;
  localparam int unsigned CH_W  = $clog2(NCH);
  localparam int unsigned STP_W = $clog2(SUM_BITS);
  localparam int unsigned ACC_W = ((SUM_BITS > SAMPLE_BITS + 1) ? SUM_BITS : SAMPLE_BITS + 1) + 1;

  localparam logic signed [ACC_W-1:0] SUM_MAX =
      ACC_W'({1'b0, {(SUM_BITS-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] SUM_MIN = -SUM_MAX - ACC_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_STEP,
    ST_STORE,
    ST_OUT
  } state_e;

  state_e                     state_q;
  logic [TIME_BITS-1:0]       bin_width_q;
  logic [BW-1:0]              num_bins_q;
  logic [TIME_BITS-1:0]       origin_q;
  logic                       origin_valid_q;
  logic [BW-1:0]              bin_number_q;
  logic [TIME_BITS-1:0]       bin_end_q;
  logic [CW-1:0]              events_q;
  logic signed [SUM_BITS-1:0] sums_q [NCH];
  logic                       done_q;

  logic signed [SUM_BITS-1:0] snap_q [NCH];
  logic [CW-1:0]              snap_cnt_q;
  logic [BW-1:0]              snap_bin_q;
  logic [CH_W-1:0]            ch_q;
  logic [STP_W-1:0]           step_q;
  logic [CW-1:0]              rem_q;
  logic [SUM_BITS-1:0]        quo_q;
  logic                       neg_q;
  logic [SUM_BITS-1:0]        res_q [NCH];

  logic                       out_valid_q;
  logic [BW-1:0]              bin_index_q;
  logic [CW-1:0]              event_count_q;
  logic [SUM_BITS-1:0]        mean_q [NCH];

  logic signed [SAMPLE_BITS-1:0] amp [NCH];
  logic                       in_fire;
  logic                       active;
  logic                       closes;
  logic [TIME_BITS-1:0]       org;
  logic [TIME_BITS-1:0]       bend;
  logic [TIME_BITS-1:0]       offset;
  logic [TIME_BITS:0]         bend_sum;
  logic [TIME_BITS-1:0]       bend_next;
  logic [BW-1:0]              bin_next;
  logic [BW-1:0]              limit;
  logic                       last_bin;
  logic [CW-1:0]              events_inc;
  logic signed [SUM_BITS-1:0] acc_next [NCH];

  logic signed [SUM_BITS-1:0] snap_sel;
  logic [SUM_BITS-1:0]        snap_mag;
  logic [CW:0]                rem_sh;
  logic                       rem_ge;
  logic [CW-1:0]              rem_next;
  logic [SUM_BITS-1:0]        quo_res;
  logic                       out_free;
  logic                       out_load;

  assign amp[0] = amp_a_i;
  assign amp[1] = amp_b_i;
  assign amp[2] = amp_c_i;
  assign amp[3] = amp_d_i;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // event bookkeeping
  always_comb begin
    active     = !done_q && (origin_valid_q || event_start_i);
    org        = origin_valid_q ? origin_q : event_time_i;
    bend       = origin_valid_q ? bin_end_q : bin_width_q;
    offset     = event_time_i - org;
    closes     = event_start_i && (offset > bend);
    bend_sum   = {1'b0, bend} + {1'b0, bin_width_q};
    bend_next  = bend_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : bend_sum[TIME_BITS-1:0];
    bin_next   = bin_number_q + BW'(1);
    limit      = (num_bins_q == '0) ? BW'(1) : num_bins_q;
    last_bin   = (bin_next >= limit);
    events_inc = (events_q == {CW{1'b1}}) ? events_q : events_q + CW'(1);
  end

  // saturating charge accumulation, charge is the negated sample
  always_comb begin
    logic signed [ACC_W-1:0] base;
    logic signed [ACC_W-1:0] wide;
    for (int c = 0; c < NCH; c++) begin
      base = closes ? '0 : ACC_W'(sums_q[c]);
      wide = base - ACC_W'(amp[c]);
      if (wide > SUM_MAX) begin
        acc_next[c] = SUM_BITS'(SUM_MAX);
      end else if (wide < SUM_MIN) begin
        acc_next[c] = SUM_BITS'(SUM_MIN);
      end else begin
        acc_next[c] = SUM_BITS'(wide);
      end
    end
  end

  // shared divider: one quotient bit per cycle on the magnitude
  always_comb begin
    snap_sel = snap_q[ch_q];
    snap_mag = snap_sel[SUM_BITS-1] ? -snap_sel : snap_sel;
    rem_sh   = {rem_q, quo_q[SUM_BITS-1]};
    rem_ge   = (rem_sh >= {1'b0, snap_cnt_q});
    rem_next = rem_ge ? CW'(rem_sh - {1'b0, snap_cnt_q}) : rem_sh[CW-1:0];
    if (snap_cnt_q == '0) begin
      quo_res = '0;
    end else begin
      quo_res = neg_q ? -quo_q : quo_q;
    end
    out_free = !out_valid_q || out_ready_i;
    out_load = (state_q == ST_OUT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      bin_width_q    <= TIME_BITS'(tbci_pkg::BIN_WIDTH_RST);
      num_bins_q     <= tbci_pkg::NUM_BINS_RST;
      origin_q       <= '0;
      origin_valid_q <= 1'b0;
      bin_number_q   <= '0;
      bin_end_q      <= '0;
      events_q       <= '0;
      done_q         <= 1'b0;
      snap_cnt_q     <= '0;
      snap_bin_q     <= '0;
      ch_q           <= '0;
      step_q         <= '0;
      rem_q          <= '0;
      quo_q          <= '0;
      neg_q          <= 1'b0;
      out_valid_q    <= 1'b0;
      bin_index_q    <= '0;
      event_count_q  <= '0;
      for (int c = 0; c < NCH; c++) begin
        sums_q[c] <= '0;
        snap_q[c] <= '0;
        res_q[c]  <= '0;
        mean_q[c] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tbci_pkg::REG_BIN_WIDTH: bin_width_q <= cfg_wdata_i;
          tbci_pkg::REG_NUM_BINS:  num_bins_q  <= cfg_wdata_i[BW-1:0];
          default: ;
        endcase
      end

      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire && active) begin
            if (!origin_valid_q) begin
              origin_q       <= event_time_i;
              origin_valid_q <= 1'b1;
              bin_end_q      <= bin_width_q;
            end
            if (closes) begin
              for (int c = 0; c < NCH; c++) begin
                snap_q[c] <= sums_q[c];
              end
              snap_cnt_q   <= events_q;
              snap_bin_q   <= bin_number_q;
              bin_number_q <= bin_next;
              bin_end_q    <= bend_next;
              ch_q         <= '0;
              state_q      <= ST_LOAD;
              if (last_bin) begin
                done_q   <= 1'b1;
                events_q <= '0;
                for (int c = 0; c < NCH; c++) begin
                  sums_q[c] <= '0;
                end
              end else begin
                events_q <= CW'(1);
                sums_q   <= acc_next;
              end
            end else begin
              if (event_start_i) begin
                events_q <= events_inc;
              end
              sums_q <= acc_next;
            end
          end
        end
        ST_LOAD: begin
          quo_q   <= snap_mag;
          neg_q   <= snap_sel[SUM_BITS-1];
          rem_q   <= '0;
          step_q  <= STP_W'(SUM_BITS - 1);
          state_q <= ST_STEP;
        end
        ST_STEP: begin
          rem_q  <= rem_next;
          quo_q  <= {quo_q[SUM_BITS-2:0], rem_ge};
          step_q <= step_q - STP_W'(1);
          if (step_q == '0) begin
            state_q <= ST_STORE;
          end
        end
        ST_STORE: begin
          res_q[ch_q] <= quo_res;
          if (ch_q == CH_W'(NCH - 1)) begin
            state_q <= ST_OUT;
          end else begin
            ch_q    <= ch_q + CH_W'(1);
            state_q <= ST_LOAD;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_valid_q   <= 1'b1;
            bin_index_q   <= snap_bin_q;
            event_count_q <= snap_cnt_q;
            mean_q        <= res_q;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign bin_index_o   = bin_index_q;
  assign event_count_o = event_count_q;
  assign mean_a_o      = mean_q[0];
  assign mean_b_o      = mean_q[1];
  assign mean_c_o      = mean_q[2];
  assign mean_d_o      = mean_q[3];

  a_close_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && active && closes |=> !in_ready_o)
    else $error("closing word did not start the divider");

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> done_q)
    else $error("done flag cleared");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_OUT))
    else $error("result word raised outside the output step");

  a_step_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_STEP && step_q == '0 |=> state_q == ST_STORE)
    else $error("divider did not finish after its last step");

endmodule

`default_nettype wire

// ===== tb/time_binned_charge_integrator_test.sv =====
`timescale 1ns / 1ps

module time_binned_charge_integrator_test;

  localparam int unsigned SAMP_W = 16;
  localparam int unsigned TIME_W = 48;
  localparam int unsigned SUM_W  = 48;

  localparam logic [TIME_W-1:0] ORIGIN   = 48'hFFFF_FFFF_FFF0;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam longint SUM_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned QUIET_LIMIT  = 20000;
  localparam int unsigned HOLD_CYCLES  = 1500;

  typedef struct packed {
    logic                                    start;
    logic [TIME_W-1:0]                       t;
    logic [tbci_pkg::NUM_CH-1:0][SAMP_W-1:0] amp;
  } sample_word_t;

  typedef struct packed {
    logic [tbci_pkg::BIN_BITS-1:0]          idx;
    logic [tbci_pkg::CNT_BITS-1:0]          count;
    logic [tbci_pkg::NUM_CH-1:0][SUM_W-1:0] mean;
  } bin_result_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                cfg_we_i = 1'b0;
  logic                                cfg_idx_i = tbci_pkg::REG_BIN_WIDTH;
  logic [tbci_pkg::CFG_BITS-1:0]       cfg_wdata_i = '0;
  logic                                in_valid_i = 1'b0;
  logic                                in_ready_o;
  logic                                event_start_i = 1'b0;
  logic [TIME_W-1:0]                   event_time_i = '0;
  logic signed [SAMP_W-1:0]            amp_a_i = '0;
  logic signed [SAMP_W-1:0]            amp_b_i = '0;
  logic signed [SAMP_W-1:0]            amp_c_i = '0;
  logic signed [SAMP_W-1:0]            amp_d_i = '0;
  logic                                out_valid_o;
  logic                                out_ready_i = 1'b0;
  logic [tbci_pkg::BIN_BITS-1:0]       bin_index_o;
  logic [tbci_pkg::CNT_BITS-1:0]       event_count_o;
  logic signed [SUM_W-1:0]             mean_a_o;
  logic signed [SUM_W-1:0]             mean_b_o;
  logic signed [SUM_W-1:0]             mean_c_o;
  logic signed [SUM_W-1:0]             mean_d_o;

  time_binned_charge_integrator #(
    .SAMPLE_BITS(SAMP_W),
    .TIME_BITS  (TIME_W),
    .SUM_BITS   (SUM_W)
  ) uut (.*);

  always #4 clk_i = ~clk_i;

  // integrator state as the block should hold it
  logic [TIME_W-1:0]             bin_width_reg = tbci_pkg::BIN_WIDTH_RST;
  logic [tbci_pkg::BIN_BITS-1:0] num_bins_reg  = tbci_pkg::NUM_BINS_RST;
  logic [TIME_W-1:0]             origin_at     = '0;
  logic                          origin_set    = 1'b0;
  logic [tbci_pkg::BIN_BITS-1:0] bin_no        = '0;
  logic [TIME_W-1:0]             bin_end_at    = '0;
  logic [tbci_pkg::CNT_BITS-1:0] bin_events    = '0;
  longint                        charge [tbci_pkg::NUM_CH];
  logic                          bins_exhausted = 1'b0;

  sample_word_t    pending [$];
  bin_result_t     bins_due [$];
  sample_word_t    cur_word;
  int unsigned     send_idle = 10;
  int unsigned     recv_idle = 50;
  int unsigned     mismatches = 0;
  int unsigned     quiet_cycles = 0;
  logic            hold_arm = 1'b0;
  logic            hold_used = 1'b0;
  int unsigned     hold_left = 0;
  longint unsigned cursor = 0;

  initial begin
    for (int c = 0; c < tbci_pkg::NUM_CH; c++) charge[c] = 0;
  end

  task automatic integrate_word(input sample_word_t w);
    logic [TIME_W-1:0]             offset;
    logic [tbci_pkg::BIN_BITS-1:0] lim;
    bin_result_t                   r;
    longint                        cnt;
    longint                        q;
    longint                        s;
    if (bins_exhausted) return;
    if (!origin_set) begin
      if (!w.start) return;
      origin_at  = w.t;
      origin_set = 1'b1;
      bin_end_at = bin_width_reg;
    end
    if (w.start) begin
      offset = w.t - origin_at;
      if (offset > bin_end_at) begin
        lim = (num_bins_reg == '0) ? tbci_pkg::BIN_BITS'(1) : num_bins_reg;
        r.idx   = bin_no;
        r.count = bin_events;
        cnt = {32'b0, bin_events};
        for (int c = 0; c < tbci_pkg::NUM_CH; c++) begin
          q = (cnt == 0) ? 0 : charge[c] / cnt;
          r.mean[c] = q[SUM_W-1:0];
          charge[c] = 0;
        end
        bins_due.push_back(r);
        bin_events = '0;
        bin_no = bin_no + 1'b1;
        if (bin_end_at > TIME_MAX - bin_width_reg) bin_end_at = TIME_MAX;
        else bin_end_at = bin_end_at + bin_width_reg;
        if (bin_no >= lim) begin
          bins_exhausted = 1'b1;
          return;
        end
      end
      if (bin_events != '1) bin_events = bin_events + 1'b1;
    end
    for (int c = 0; c < tbci_pkg::NUM_CH; c++) begin
      s = charge[c] - longint'($signed(w.amp[c]));
      if (s > SUM_HI) s = SUM_HI;
      if (s < SUM_LO) s = SUM_LO;
      charge[c] = s;
    end
  endtask

  // sender
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) integrate_word(cur_word);
      if (!in_valid_i || in_ready_o) begin
        if (pending.size() != 0 && $urandom_range(99) >= send_idle) begin
          cur_word = pending.pop_front();
          event_start_i <= cur_word.start;
          event_time_i  <= cur_word.t;
          amp_a_i       <= cur_word.amp[0];
          amp_b_i       <= cur_word.amp[1];
          amp_c_i       <= cur_word.amp[2];
          amp_d_i       <= cur_word.amp[3];
          in_valid_i    <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver, with one long hold-off
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (hold_arm && !hold_used) begin
      hold_left   <= HOLD_CYCLES;
      hold_used   <= 1'b1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic check_field(input string name, input logic [SUM_W-1:0] want,
                             input logic [SUM_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    bin_result_t want;
    logic [tbci_pkg::NUM_CH-1:0][SUM_W-1:0] got_mean;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (bins_due.size() == 0) begin
        $display("%0t: unexpected result word, bin %0d", $time, bin_index_o);
        mismatches++;
      end else begin
        want = bins_due.pop_front();
        got_mean = {mean_d_o, mean_c_o, mean_b_o, mean_a_o};
        check_field("bin_index", SUM_W'(want.idx), SUM_W'(bin_index_o));
        check_field("event_count", SUM_W'(want.count), SUM_W'(event_count_o));
        check_field("mean_a", want.mean[0], got_mean[0]);
        check_field("mean_b", want.mean[1], got_mean[1]);
        check_field("mean_c", want.mean[2], got_mean[2]);
        check_field("mean_d", want.mean[3], got_mean[3]);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[TIME_W-1:0];
  endfunction

  function automatic logic [SAMP_W-1:0] pick_amp();
    unique case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return SAMP_W'($urandom);
    endcase
  endfunction

  task automatic queue_word(input logic start, input logic [TIME_W-1:0] t,
                            input bit flat = 1'b0, input logic [SAMP_W-1:0] level = '0);
    sample_word_t w;
    w.start = start;
    w.t     = t;
    for (int c = 0; c < tbci_pkg::NUM_CH; c++) w.amp[c] = flat ? level : pick_amp();
    pending.push_back(w);
  endtask

  // events of random length; times mostly move forward at about one bin per few events
  task automatic queue_burst(input int n_words, input logic [TIME_W-1:0] width);
    longint unsigned step_max;
    longint unsigned d;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] back;
    int left;
    int len;
    left = n_words;
    cursor = 64'(bin_end_at);
    step_max = 64'(width) / 3 + 1;
    while (left > 0) begin
      len = int'($urandom_range(6, 1));
      if (len > left) len = left;
      case ($urandom_range(19))
        0, 1: t = rand_time();
        2: begin
          back = TIME_W'($urandom_range(5));
          t = ORIGIN + cursor[TIME_W-1:0] - back;
        end
        default: begin
          d = {$urandom, $urandom};
          cursor = cursor + d % (step_max + 1);
          t = ORIGIN + cursor[TIME_W-1:0];
        end
      endcase
      queue_word(1'b1, t);
      for (int i = 1; i < len; i++) queue_word(1'b0, rand_time());
      left -= len;
    end
  endtask

  task automatic write_reg(input logic idx, input logic [tbci_pkg::CFG_BITS-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == tbci_pkg::REG_BIN_WIDTH) bin_width_reg = val[TIME_W-1:0];
    else num_bins_reg = val[tbci_pkg::BIN_BITS-1:0];
  endtask

  task automatic settle();
    while (pending.size() != 0 || in_valid_i || bins_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [63:0] r64;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero bin width: every event off the origin time closes a bin
    write_reg(tbci_pkg::REG_BIN_WIDTH, '0);
    write_reg(tbci_pkg::REG_NUM_BINS, tbci_pkg::CFG_BITS'(16'hFFFF));
    queue_word(1'b0, rand_time(), 1'b1, 16'h7FFF);
    queue_word(1'b0, rand_time(), 1'b1, 16'h8000);
    queue_word(1'b1, ORIGIN, 1'b1, 16'h8000);
    queue_word(1'b0, rand_time(), 1'b1, 16'h7FFF);
    queue_word(1'b1, ORIGIN, 1'b1, 16'hFFFF);
    queue_word(1'b1, ORIGIN + 48'd1);
    queue_word(1'b0, rand_time());
    queue_word(1'b1, 48'h0000_0000_0010);
    queue_word(1'b1, 48'hFFFF_FFFF_FFFF);
    queue_word(1'b1, 48'h7FFF_FFFF_FFFF, 1'b1, 16'h7FFF);
    queue_word(1'b1, ORIGIN, 1'b1, 16'h0000);
    queue_word(1'b1, ORIGIN - 48'd1);
    settle();

    write_reg(tbci_pkg::REG_BIN_WIDTH, tbci_pkg::CFG_BITS'(1));
    queue_burst(260, 48'd1);
    hold_arm <= 1'b1;
    settle();

    write_reg(tbci_pkg::REG_BIN_WIDTH, tbci_pkg::CFG_BITS'($urandom_range(64, 2)));
    write_reg(tbci_pkg::REG_NUM_BINS, tbci_pkg::CFG_BITS'(60000));
    queue_burst(260, bin_width_reg);
    settle();

    send_idle = 50;
    recv_idle = 10;
    write_reg(tbci_pkg::REG_BIN_WIDTH, tbci_pkg::CFG_BITS'($urandom_range(1 << 20, 1000)));
    queue_burst(260, bin_width_reg);
    settle();

    r64 = 64'($urandom_range(255));
    r64 = (r64 << 32) | 64'($urandom);
    write_reg(tbci_pkg::REG_BIN_WIDTH, r64[tbci_pkg::CFG_BITS-1:0] + 48'h10_0000_0000);
    queue_burst(260, bin_width_reg);
    settle();

    send_idle = 0;
    recv_idle = 0;
    write_reg(tbci_pkg::REG_BIN_WIDTH, tbci_pkg::BIN_WIDTH_RST);
    queue_burst(240, bin_width_reg);
    settle();

    // zero bin count acts as one: the next closure is the last,
    // and the widest bin saturates the bin end
    write_reg(tbci_pkg::REG_NUM_BINS, '0);
    write_reg(tbci_pkg::REG_BIN_WIDTH, '1);
    queue_word(1'b1, origin_at + bin_end_at);
    queue_word(1'b1, origin_at + bin_end_at + 48'd1);
    queue_word(1'b1, origin_at - 48'd1);
    queue_word(1'b0, rand_time());
    queue_word(1'b1, rand_time());
    queue_word(1'b1, origin_at + 48'd1, 1'b1, 16'h8000);
    settle();

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
